>>> rtl/adc_clip_pkg.sv
// ----------------------------------------------------------------------------
// adc_clip_pkg
// Widths, limits and the saturating counter helper for the ADC clipping counter.
// ----------------------------------------------------------------------------
package adc_clip_pkg;

	localparam int unsigned SAMPLE_WIDTH = 16;
	localparam int unsigned SAMPLE_TDATA_W = 16;
	localparam longint unsigned MAX_RECORD = 64'd1048576;

	localparam int unsigned CNT_W = 21;
	localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;
	localparam logic [CNT_W-1:0] CNT_CAP =
		(MAX_RECORD < CNT_MAX) ? CNT_W'(MAX_RECORD) : CNT_W'(CNT_MAX);

	localparam int unsigned ADC_BITS_W = 5;
	localparam logic [ADC_BITS_W-1:0] ADC_BITS_RESET = ADC_BITS_W'(8);

	localparam int unsigned RESULT_W = 4 * CNT_W;
	localparam int unsigned RESULT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		cnt_t bottom_run;
		cnt_t top_run;
		cnt_t bottom;
		cnt_t top;
	} rail_cnt_t;

	function automatic cnt_t sat_add(input cnt_t c, input logic [1:0] amt);
		logic [CNT_W:0] v;
		v = {1'b0, c} + (CNT_W + 1)'(amt);
		return (v > {1'b0, CNT_CAP}) ? CNT_CAP : v[CNT_W-1:0];
	endfunction

endpackage

>>> rtl/adc_clipping_counter.sv
// Result: a record's result is registered in result_q when its last sample leaves the input stage.
// Throughput: one sample per cycle; the input stage and the result register
// decouple the two sides, so only a stalled result with a second record's last
// sample waiting holds the input.
// Reset: arst_n clears the running counters and the valid and record flags, adc_bits returns to 8.
// ----------------------------------------------------------------------------
// adc_clipping_counter
// Counts top-rail, zero and neighboring rail samples over one record and
// emits the four saturating counts on the record's last sample.
// ----------------------------------------------------------------------------
module adc_clipping_counter
	import adc_clip_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ADC_BITS_W-1:0]      cfg_wr_data,    // adc_bits
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [SAMPLE_TDATA_W-1:0]  s_tdata,        // sample
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [RESULT_TDATA_W-1:0]  m_tdata         // top_count, bottom_count,
	                                                   // top_run_count, bottom_run_count
);

	logic [ADC_BITS_W-1:0]   adc_bits_q;

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic                    last_s1;

	logic                    prev_top_q;
	logic                    prev_bottom_q;
	logic                    prev_top_counted_q;
	logic                    prev_bottom_counted_q;
	logic                    record_started_q;
	rail_cnt_t               cnt_q;
	rail_cnt_t               cnt_nxt;
	rail_cnt_t               result_q;
	logic                    result_valid_q;

	logic                    advance;
	logic                    bits_ok;
	logic [SAMPLE_WIDTH:0]   top_code;
	logic                    is_top;
	logic                    is_bottom;
	logic                    top_pair;
	logic                    bottom_pair;

	assign advance  = valid_s1 && (!last_s1 || !result_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign bits_ok   = adc_bits_q <= ADC_BITS_W'(SAMPLE_WIDTH);
	assign top_code  = ((SAMPLE_WIDTH + 1)'(1) << adc_bits_q) - (SAMPLE_WIDTH + 1)'(1);
	assign is_top    = bits_ok && ({1'b0, sample_s1} >= top_code);
	assign is_bottom = sample_s1 == '0;
	assign top_pair    = record_started_q && is_top && prev_top_q;
	assign bottom_pair = record_started_q && is_bottom && prev_bottom_q;

	always_comb begin
		cnt_nxt = cnt_q;
		if (is_top) begin
			cnt_nxt.top = sat_add(cnt_q.top, 2'd1);
		end
		if (is_bottom) begin
			cnt_nxt.bottom = sat_add(cnt_q.bottom, 2'd1);
		end
		if (top_pair) begin
			cnt_nxt.top_run = sat_add(cnt_q.top_run, prev_top_counted_q ? 2'd1 : 2'd2);
		end
		if (bottom_pair) begin
			cnt_nxt.bottom_run =
				sat_add(cnt_q.bottom_run, prev_bottom_counted_q ? 2'd1 : 2'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_bits_q <= ADC_BITS_RESET;
		end else if (cfg_wr_en) begin
			adc_bits_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[SAMPLE_WIDTH-1:0];
			last_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_top_q            <= 1'b0;
			prev_bottom_q         <= 1'b0;
			prev_top_counted_q    <= 1'b0;
			prev_bottom_counted_q <= 1'b0;
			record_started_q      <= 1'b0;
			cnt_q                 <= '0;
		end else if (advance) begin
			if (last_s1) begin
				prev_top_q            <= 1'b0;
				prev_bottom_q         <= 1'b0;
				prev_top_counted_q    <= 1'b0;
				prev_bottom_counted_q <= 1'b0;
				record_started_q      <= 1'b0;
				cnt_q                 <= '0;
			end else begin
				prev_top_q            <= is_top;
				prev_bottom_q         <= is_bottom;
				prev_top_counted_q    <= top_pair;
				prev_bottom_counted_q <= bottom_pair;
				record_started_q      <= 1'b1;
				cnt_q                 <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (m_tready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= cnt_nxt;
		end
	end

	assign m_tvalid = result_valid_q;
	assign m_tdata  = RESULT_TDATA_W'({result_q.bottom_run, result_q.top_run,
	                                   result_q.bottom, result_q.top});

`ifndef NO_ASSERTIONS
	a_run_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_q.top_run <= result_q.top))
		else $error("top run count exceeds top count");

	a_run_le_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_q.bottom_run <= result_q.bottom))
		else $error("bottom run count exceeds bottom count");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (!record_started_q && cnt_q == '0))
		else $error("record state not cleared after last sample");

	a_counted_implies_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!prev_top_counted_q || prev_top_q) && (!prev_bottom_counted_q || prev_bottom_q))
		else $error("run flag set without matching rail flag");
`endif

endmodule
